### sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge while reset is released
`define PF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must hold on every cycle a result is offered
`define PF_ASSERT_ON_VALID(lbl, clk, rst_n, vld, cond, msg) \
    `PF_ASSERT(lbl, clk, rst_n, (vld) |-> (cond), msg)

`endif

### sv/pf_pkg.sv
// shared codes of the packet fifo: request opcodes and result status codes
// no dependencies
`default_nettype none

package pf_pkg;

    // request opcodes carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

### sv/packet_fifo.sv
// packet fifo top level: byte store, length store, write control and read streaming
// depends on pf_pkg
//
//  channel | dir | tdata (low bit up)                                  | tuser  | tlast
//  s_*     | in  | data_byte                                           | opcode | last_byte
//  m_*     | out | out_byte, packet_length, packets_held, is_empty, 0s | status | out_last
//
// the result of a write or an empty read is registered and offered from the next cycle.
// a read reads the length store as it is taken, latches the length in S_LEN and then
// fetches the bytes in S_STREAM through the read register into the result register;
// bytes go out one per cycle while m_tready is high, and the next request follows the last.
// a new request is taken only when no read is active and the result register is free or
// being emptied; a stalled result stalls both sides, the fetched byte waits in the read register.
// reset clears the slot pointers, counters and drop state; the stores need no clearing.
`default_nettype none

module packet_fifo #(
    parameter int MAX_PACKET_BYTES = 64,
    parameter int PACKET_SLOTS     = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte
    input  wire logic                 s_tuser,   // opcode
    input  wire logic                 s_tlast,   // last_byte
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [(($clog2(MAX_PACKET_BYTES + 1) + $clog2(PACKET_SLOTS + 1) + 16) / 8) * 8 - 1:0]
                                      m_tdata,   // out_byte, packet_length, packets_held, is_empty
    output logic [1:0]                m_tuser,   // status
    output logic                      m_tlast    // out_last
);

    localparam int OFFW      = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
    localparam int LENW      = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CNTW      = $clog2(PACKET_SLOTS + 1);
    localparam int SLW       = $clog2(PACKET_SLOTS);
    localparam int ADDRW     = SLW + OFFW;
    localparam int DEPTH     = PACKET_SLOTS * (2 ** OFFW);
    localparam int DATA_BITS = 8 + LENW + CNTW + 1;
    localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

    localparam logic [LENW-1:0] MAX_LEN   = LENW'(MAX_PACKET_BYTES);
    localparam logic [CNTW-1:0] ALL_SLOTS = CNTW'(PACKET_SLOTS);
    localparam logic [SLW-1:0]  LAST_SLOT = SLW'(PACKET_SLOTS - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    // control state
    logic [1:0]      state_reg, state_next;
    logic [SLW-1:0]  head_reg, head_next;
    logic [SLW-1:0]  tail_reg, tail_next;
    logic [SLW-1:0]  rd_slot_reg, rd_slot_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [LENW-1:0] wr_off_reg, wr_off_next;
    logic [1:0]      drop_reg, drop_next;
    logic [LENW-1:0] len_reg, len_next;
    logic [LENW-1:0] fetch_reg, fetch_next;
    logic            pend_reg, pend_next;
    logic            pend_last_reg, pend_last_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic [1:0]      status_reg, status_next;
    logic [LENW-1:0] out_len_reg, out_len_next;
    logic [CNTW-1:0] held_reg, held_next;
    logic            empty_reg, empty_next;

    // store ports
    logic [7:0]      byte_mem [DEPTH];
    logic [LENW-1:0] len_mem [PACKET_SLOTS];
    logic [7:0]      byte_rdata_reg;
    logic [LENW-1:0] len_rdata_reg;
    logic            byte_we, byte_re, len_we, len_re;
    logic [ADDRW-1:0] byte_waddr, byte_raddr;
    logic [LENW-1:0] wr_off_inc;

    logic in_acc, load;
    logic res_en;
    logic [1:0] res_status;

    function automatic logic [SLW-1:0] next_slot(input logic [SLW-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : SLW'(s + 1'b1);
    endfunction

    // handshake
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign load     = pend_reg && (!out_valid_reg || m_tready);

    assign wr_off_inc = LENW'(wr_off_reg + 1'b1);
    assign byte_waddr = {tail_reg, wr_off_reg[OFFW-1:0]};
    assign byte_raddr = {rd_slot_reg, fetch_reg[OFFW-1:0]};

    // next-state logic for requests, stream and result register
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rd_slot_next   = rd_slot_reg;
        count_next     = count_reg;
        wr_off_next    = wr_off_reg;
        drop_next      = drop_reg;
        len_next       = len_reg;
        fetch_next     = fetch_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        status_next    = status_reg;
        out_len_next   = out_len_reg;
        held_next      = held_reg;
        empty_next     = empty_reg;
        byte_we        = 1'b0;
        byte_re        = 1'b0;
        len_we         = 1'b0;
        len_re         = 1'b0;
        res_en         = 1'b0;
        res_status     = pf_pkg::ST_OK;

        // accepted request
        if (in_acc)
        begin
            if (s_tuser == pf_pkg::OP_READ)
            begin
                if (count_reg == '0)
                begin
                    res_en     = 1'b1;
                    res_status = pf_pkg::ST_EMPTY;
                end
                else
                begin
                    len_re       = 1'b1;
                    rd_slot_next = head_reg;
                    head_next    = next_slot(head_reg);
                    count_next   = CNTW'(count_reg - 1'b1);
                    state_next   = S_LEN;
                end
            end
            else if (drop_reg != pf_pkg::ST_OK)
            begin
                if (s_tlast)
                begin
                    res_en     = 1'b1;
                    res_status = drop_reg;
                    drop_next  = pf_pkg::ST_OK;
                end
            end
            else if (wr_off_reg == '0 && count_reg == ALL_SLOTS)
            begin
                if (s_tlast)
                begin
                    res_en     = 1'b1;
                    res_status = pf_pkg::ST_FULL;
                end
                else
                begin
                    drop_next = pf_pkg::ST_FULL;
                end
            end
            else if (wr_off_reg == MAX_LEN)
            begin
                wr_off_next = '0;
                if (s_tlast)
                begin
                    res_en     = 1'b1;
                    res_status = pf_pkg::ST_TOO_LONG;
                end
                else
                begin
                    drop_next = pf_pkg::ST_TOO_LONG;
                end
            end
            else
            begin
                byte_we     = 1'b1;
                wr_off_next = wr_off_inc;
                if (s_tlast)
                begin
                    len_we      = 1'b1;
                    tail_next   = next_slot(tail_reg);
                    count_next  = CNTW'(count_reg + 1'b1);
                    wr_off_next = '0;
                    res_en      = 1'b1;
                    res_status  = pf_pkg::ST_OK;
                end
            end
        end

        // single result of a write or of an empty read
        if (res_en)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_last_next  = 1'b1;
            status_next    = res_status;
            out_len_next   = '0;
            held_next      = count_next;
            empty_next     = (count_next == '0);
        end

        // read stream sequencer
        unique case (state_reg)
            S_LEN:
            begin
                len_next   = len_rdata_reg;
                fetch_next = '0;
                pend_next  = 1'b0;
                state_next = S_STREAM;
            end
            S_STREAM:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_rdata_reg;
                    out_last_next  = pend_last_reg;
                    status_next    = pf_pkg::ST_OK;
                    out_len_next   = len_reg;
                    held_next      = count_reg;
                    empty_next     = (count_reg == '0);
                    pend_next      = 1'b0;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if ((fetch_reg != len_reg) && (!pend_reg || load))
                begin
                    byte_re        = 1'b1;
                    fetch_next     = LENW'(fetch_reg + 1'b1);
                    pend_next      = 1'b1;
                    pend_last_next = (LENW'(fetch_reg + 1'b1) == len_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            wr_off_reg    <= '0;
            drop_reg      <= pf_pkg::ST_OK;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            wr_off_reg    <= wr_off_next;
            drop_reg      <= drop_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_slot_reg   <= rd_slot_next;
        len_reg       <= len_next;
        fetch_reg     <= fetch_next;
        pend_last_reg <= pend_last_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        status_reg    <= status_next;
        out_len_reg   <= out_len_next;
        held_reg      <= held_next;
        empty_reg     <= empty_next;
    end

    // byte store: write at the tail slot, read at the slot being streamed
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_mem[byte_waddr] <= s_tdata;
        end
        if (byte_re)
        begin
            byte_rdata_reg <= byte_mem[byte_raddr];
        end
    end

    // length store: written on commit, read at the head slot
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[tail_reg] <= wr_off_inc;
        end
        if (len_re)
        begin
            len_rdata_reg <= len_mem[head_reg];
        end
    end

    // result port
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = TDATA_W'({empty_reg, held_reg, out_len_reg, out_byte_reg});

endmodule

`default_nettype wire

### sv/pf_checker.sv
// port-level checker for the packet fifo and its bind to the top level
// depends on pf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module pf_port_checker #(
    parameter int MAX_PACKET_BYTES = 64,
    parameter int PACKET_SLOTS     = 16
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [(($clog2(MAX_PACKET_BYTES + 1) + $clog2(PACKET_SLOTS + 1) + 16) / 8) * 8 - 1:0]
                                     m_tdata,
    input wire logic [1:0]           m_tuser,
    input wire logic                 m_tlast
);

    localparam int LENW      = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CNTW      = $clog2(PACKET_SLOTS + 1);

    logic [CNTW-1:0] held;
    logic            empty;

    // result fields seen on the port
    assign held      = m_tdata[8+LENW +: CNTW];
    assign empty     = m_tdata[8+LENW+CNTW];

    // a stalled result holds its payload
    `PF_ASSERT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // empty flag agrees with the packet count
    `PF_ASSERT_ON_VALID(a_empty_flag, clk, rst_n, m_tvalid, empty == (held == '0), "empty flag mismatch")

    // an empty read reports no packets held
    `PF_ASSERT_ON_VALID(a_empty_read, clk, rst_n, m_tvalid && m_tuser == pf_pkg::ST_EMPTY, empty && m_tlast, "bad empty read result")

    // only stream bytes precede the last result of a request
    `PF_ASSERT_ON_VALID(a_mid_ok, clk, rst_n, m_tvalid && !m_tlast, m_tuser == pf_pkg::ST_OK, "error status mid stream")

    // a new request is taken over a waiting result only while the result register drains
    `PF_ASSERT(a_no_overrun, clk, rst_n, s_tvalid && s_tready && m_tvalid |-> m_tready, "request taken over waiting result")

endmodule

bind packet_fifo pf_port_checker #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .PACKET_SLOTS(PACKET_SLOTS)
) u_pf_port_checker (.*);

`default_nettype wire
